// File: design/sia_pkg.sv
// Shared constants for the scaled univariate interpolation block.
// No dependencies; the top level and the checker refer to it by scoped names.
`default_nettype none
package sia_pkg;
  localparam int MAX_DEGREE  = 16;  // deepest sample set
  localparam int WORD_BITS   = 64;  // arithmetic word, wraps modulo 2^WORD_BITS
  localparam int FIELD_BITS  = 64;  // width of the value and coefficient ports
  localparam int INDEX_BITS  = 4;   // width of the index port
endpackage
`default_nettype wire

// File: design/sia_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module sia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                     rdata_a,
  output logic      [WIDTH-1:0]                     rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// File: design/sia_serial_alu.sv
// Bit-serial unit: result = p*a - q*b modulo 2^W, LSB first, one bit a cycle while shift is high.
// No dependencies; p and q are small unsigned multipliers.
`default_nettype none
module sia_serial_alu #(
  parameter int W  = 64,
  parameter int CW = 5
) (
  input  wire logic          clk,
  input  wire logic          load,
  input  wire logic          shift,
  input  wire logic [W-1:0]  a,
  input  wire logic [W-1:0]  b,
  input  wire logic [CW-1:0] p,
  input  wire logic [CW-1:0] q,
  output logic      [W-1:0]  result
);
  localparam int TW = CW + 3;

  logic [W-1:0]          sa;
  logic [W-1:0]          sb;
  logic signed [TW-1:0]  carry;
  logic signed [TW-1:0]  t;
  logic signed [TW-1:0]  pa;
  logic signed [TW-1:0]  qb;

  always_comb begin
    pa = sa[0] ? $signed(TW'(p)) : '0;
    qb = sb[0] ? $signed(TW'(q)) : '0;
    t  = pa - qb + carry;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sa    <= a;
      sb    <= b;
      carry <= '0;
    end else if (shift) begin
      sa     <= sa >> 1;
      sb     <= sb >> 1;
      carry  <= t >>> 1;
      result <= {t[0], result[W-1:1]};
    end
  end
endmodule
`default_nettype wire

// File: design/scaled_univariate_interpolation_top.sv
// Scaled univariate interpolation: samples in, D!-scaled monomial coefficients out.
// Depends on sia_pkg, sia_ram and sia_serial_alu.
//
// Usage:
//  - Sample channel (value, last, sample_valid/sample_ready): push D words in
//    index order; last marks the final word. The MAX_DEGREE-th word closes the
//    set on its own. sample_ready is high only while words are being loaded.
//  - Coefficient channel (coefficient, index, final_res, coef_valid/coef_ready):
//    D words in index order, final_res on the last one.
//  - Each operation of the three phases (difference, scale, expand) reads two
//    store words, streams them through the bit-serial unit and writes one
//    word back. A set of D words takes about 3*D*D/2 operations; the serial
//    unit is what sets how long each operation takes.
//  - Each coefficient passes through S_OUT_RD, S_OUT_WAIT and S_OUT, plus
//    receiver stall time; the output register holds each word until coef_ready.
//  - Reset clears the fill count and the state machine; store contents are
//    left as they are and are only read after being written.
//  - A stalled receiver freezes the block; no word is lost or repeated.
`default_nettype none
module scaled_univariate_interpolation_top #(
  parameter int MAX_DEGREE = sia_pkg::MAX_DEGREE,
  parameter int WORD_BITS  = sia_pkg::WORD_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [sia_pkg::FIELD_BITS-1:0]   value,
  input  wire logic                             last,
  input  wire logic                             sample_valid,
  output logic                                  sample_ready,
  output logic [sia_pkg::FIELD_BITS-1:0]        coefficient,
  output logic [sia_pkg::INDEX_BITS-1:0]        index,
  output logic                                  final_res,
  output logic                                  coef_valid,
  input  wire logic                             coef_ready
);
  localparam int LW  = $clog2(MAX_DEGREE + 1);
  localparam int IW  = MAX_DEGREE > 1 ? $clog2(MAX_DEGREE) : 1;
  localparam int BCW = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    S_LOAD, S_ISSUE, S_FETCH, S_RUN, S_WRITE, S_OUT_RD, S_OUT_WAIT, S_OUT
  } state_t;
  typedef enum logic [1:0] { PH_DIFF, PH_SCALE, PH_EXPAND } phase_t;

  state_t           state;
  phase_t           ph;
  logic [LW-1:0]    cnt;      // words loaded so far
  logic [LW-1:0]    d;        // set size
  logic [LW-1:0]    u;        // outer loop counter
  logic [LW-1:0]    v;        // inner loop counter
  logic [BCW-1:0]   bitc;

  logic [LW-1:0]    x, y, p, q, lo, dm1, dm2, cnt_next;
  logic             accept, set_done;
  logic             we;
  logic [IW-1:0]    waddr, raddr_a;
  logic [WORD_BITS-1:0] wdata, rdata_a, rdata_b, alu_res;
  logic [LW+3:0]    u_wide;

  assign sample_ready = (state == S_LOAD);
  assign accept       = sample_valid && sample_ready;
  assign cnt_next     = cnt + LW'(1);
  assign set_done     = last || (cnt_next == LW'(MAX_DEGREE));
  assign dm1          = d - LW'(1);
  assign dm2          = d - LW'(2);
  assign lo           = (u > LW'(2)) ? u - LW'(1) : LW'(1);
  assign u_wide       = (LW + 4)'(u);

  // Operands of the current operation: A[x] = p*A[x] - q*A[y].
  always_comb begin
    case (ph)
      PH_DIFF: begin
        x = v; y = v - LW'(1); p = LW'(1); q = LW'(1);
      end
      PH_SCALE: begin
        x = u; y = u; p = v; q = '0;
      end
      PH_EXPAND: begin
        x = v - LW'(1); y = v; p = LW'(1); q = v - u;
      end
      default: begin
        x = '0; y = '0; p = '0; q = '0;
      end
    endcase
  end

  // Store ports: load writes share the write port with write-back.
  always_comb begin
    we      = accept || (state == S_WRITE);
    waddr   = accept ? cnt[IW-1:0] : x[IW-1:0];
    wdata   = accept ? value[WORD_BITS-1:0] : alu_res;
    raddr_a = (state == S_OUT_RD) ? u[IW-1:0] : x[IW-1:0];
  end

  sia_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_DEGREE)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (y[IW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  sia_serial_alu #(.W(WORD_BITS), .CW(LW)) u_alu (
    .clk    (clk),
    .load   (state == S_FETCH),
    .shift  (state == S_RUN),
    .a      (rdata_a),
    .b      (rdata_b),
    .p      (p),
    .q      (q),
    .result (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      ph         <= PH_DIFF;
      cnt        <= '0;
      coef_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            cnt <= cnt_next;
            if (set_done) begin
              d <= cnt_next;
              if (cnt_next == LW'(1)) begin
                // single word: nothing to compute, emit it as is
                u     <= '0;
                state <= S_OUT_RD;
              end else begin
                ph    <= PH_DIFF;
                u     <= LW'(1);
                v     <= cnt;
                state <= S_ISSUE;
              end
            end
          end
        end
        S_ISSUE: state <= S_FETCH;
        S_FETCH: begin
          bitc  <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          bitc <= bitc + BCW'(1);
          if (bitc == BCW'(WORD_BITS - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_ISSUE;
          case (ph)
            PH_DIFF: begin
              if (v > lo) begin
                v <= v - LW'(1);
              end else if (u < d) begin
                u <= u + LW'(1);
                v <= dm1;
              end else begin
                ph <= PH_SCALE;
                u  <= '0;
                v  <= LW'(2);
              end
            end
            PH_SCALE: begin
              if (v < d) begin
                v <= v + LW'(1);
              end else if (u < dm2) begin
                u <= u + LW'(1);
                v <= u + LW'(3);
              end else begin
                ph <= PH_EXPAND;
                u  <= '0;
                v  <= dm1;
              end
            end
            PH_EXPAND: begin
              if (v > u + LW'(1)) begin
                v <= v - LW'(1);
              end else if (u < dm2) begin
                u <= u + LW'(1);
                v <= dm1;
              end else begin
                u     <= '0;
                state <= S_OUT_RD;
              end
            end
            default: state <= S_LOAD;
          endcase
        end
        S_OUT_RD: state <= S_OUT_WAIT;
        S_OUT_WAIT: begin
          coefficient <= sia_pkg::FIELD_BITS'($signed(rdata_a));
          index       <= u_wide[sia_pkg::INDEX_BITS-1:0];
          final_res   <= (u == d - LW'(1));
          coef_valid  <= 1'b1;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (coef_ready) begin
            coef_valid <= 1'b0;
            if (final_res) begin
              cnt   <= '0;
              state <= S_LOAD;
            end else begin
              u     <= u + LW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/sia_checker.sv
// Port-level checker for the interpolation top level, with its bind statement.
// Depends on sia_pkg for port widths.
`default_nettype none
module sia_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           sample_valid,
  input wire logic                           sample_ready,
  input wire logic                           last,
  input wire logic [sia_pkg::FIELD_BITS-1:0] coefficient,
  input wire logic                           final_res,
  input wire logic                           coef_valid,
  input wire logic                           coef_ready
);
  // Never take a word while a coefficient is on offer.
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    coef_valid |-> !sample_ready) else $error("sample taken during output");

  // A closing word stops loading on the next cycle.
  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready && last) |=> !sample_ready)
    else $error("loading continued after last");

  // Mid-set coefficient handoff keeps the block away from loading.
  a_mid_set: assert property (@(posedge clk) disable iff (rst)
    (coef_valid && coef_ready && !final_res) |=> !sample_ready)
    else $error("set ended before final coefficient");

  // Stalled coefficient holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (coef_valid && !coef_ready) |=> (coef_valid && $stable(coefficient)))
    else $error("stalled coefficient changed");
endmodule

bind scaled_univariate_interpolation_top sia_checker u_sia_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .last         (last),
  .coefficient  (coefficient),
  .final_res    (final_res),
  .coef_valid   (coef_valid),
  .coef_ready   (coef_ready)
);
`default_nettype wire
